>>> hw/rtl/keyhold_differential_drive_mixer_assert.svh
// assertion macros for the keyhold differential drive mixer
// used by the top level; no other dependencies
`ifndef KEYHOLD_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`define KEYHOLD_DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define KDDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kddm assertion failed");
// next-cycle implication
`define KDDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kddm assertion failed");
`else
`define KDDM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KDDM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/kddm_pkg.sv
// shared types, codes and constants of the keyhold differential drive mixer
// no dependencies; used by kddm_ctrl, kddm_dp and the top level
package kddm_pkg;

	localparam int AGE_BITS = 16;
	localparam int TMO_BITS = 16;
	localparam int CMP_BITS = (AGE_BITS > TMO_BITS) ? AGE_BITS : TMO_BITS;
	localparam int SPEED_W = 7;
	localparam int TRIM_W = 4;
	localparam int TICK_W = 7;
	localparam int KEY_W = 4;
	localparam int DIGIT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TERM_W = 10;
	localparam int N_W = 15;
	localparam int MAG_W = 14;
	localparam int X_W = 22;
	localparam int OUT_W = 8;

	typedef logic [AGE_BITS-1:0] age_t;
	typedef logic [AGE_BITS:0] age_ext_t;
	typedef logic [CMP_BITS-1:0] cmp_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [N_W-1:0] drive_t;

	localparam age_t AGE_NEVER = '1;

	localparam logic [SPEED_W-1:0] SPEED_MIN = 7'd9;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd90;
	localparam logic [SPEED_W-1:0] SPEED_STEP = 7'd9;
	localparam logic [SPEED_W-1:0] SPEED_RST = 7'd45;
	localparam logic [TRIM_W-1:0] TRIM_MIN = 4'd5;
	localparam logic [TRIM_W-1:0] TRIM_MAX = 4'd15;
	localparam logic [TRIM_W-1:0] TRIM_RST = 4'd10;
	localparam logic [TMO_BITS-1:0] TIMEOUT_RST = 16'd550;
	localparam logic [TICK_W-1:0] TICK_RST = 7'd10;

	localparam term_t SPIN_TERM = 10'sd360;
	localparam drive_t FULL_SCALE = 15'sd9000;
	localparam logic [MAG_W-1:0] HUND_HALF = 14'd45;
	// rounded-up reciprocals: 2^22/90 and 2^35/9000
	localparam logic [15:0] HUND_RECIP = 16'd46604;
	localparam int HUND_SHIFT = 22;
	localparam logic [X_W-1:0] PWM_RECIP = 22'd3817749;
	localparam int PWM_SHIFT = 35;
	// 4500 + 127*9000
	localparam logic signed [X_W:0] PWM_BIAS = 23'sd1147500;

	typedef enum logic {
		OP_KEY = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_UP = 4'd0,
		KEY_DOWN = 4'd1,
		KEY_LEFT = 4'd2,
		KEY_RIGHT = 4'd3,
		KEY_STOP = 4'd4,
		KEY_SPEED_UP = 4'd5,
		KEY_SPEED_DOWN = 4'd6,
		KEY_DIGIT = 4'd7,
		KEY_LTRIM_UP = 4'd8,
		KEY_LTRIM_DOWN = 4'd9,
		KEY_RTRIM_UP = 4'd10,
		KEY_RTRIM_DOWN = 4'd11
	} key_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_SPEED = 3'd0,
		CFG_INITIAL_LEFT_TRIM = 3'd1,
		CFG_INITIAL_RIGHT_TRIM = 3'd2,
		CFG_PWM_MODE = 3'd3,
		CFG_RELEASE_TIMEOUT = 3'd4,
		CFG_TICK_MS = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_PRE,
		ST_CONV
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic mul;
		logic pre;
		logic conv;
	} dp_cmd_t;

	typedef struct packed {
		logic op_is_tick;
	} dp_stat_t;

endpackage

>>> hw/rtl/kddm_ctrl.sv
// sequencing state machine of the keyhold differential drive mixer
// depends on kddm_pkg; drives the command struct of kddm_dp
module kddm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  kddm_pkg::dp_stat_t  stat,
	output kddm_pkg::dp_cmd_t   cmd
);

	kddm_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	// a tick may only start once the result slot is free or draining
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kddm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			kddm_pkg::ST_IDLE: begin
				in_ready = (in_op == kddm_pkg::OP_KEY) || out_free;
				if (in_valid && in_ready) begin
					cmd.load_in = 1'b1;
					state_nxt = kddm_pkg::ST_EXEC;
				end
			end
			kddm_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nxt = stat.op_is_tick ? kddm_pkg::ST_MUL : kddm_pkg::ST_IDLE;
			end
			kddm_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_nxt = kddm_pkg::ST_PRE;
			end
			kddm_pkg::ST_PRE: begin
				cmd.pre = 1'b1;
				state_nxt = kddm_pkg::ST_CONV;
			end
			kddm_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
				state_nxt = kddm_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = kddm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.conv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/kddm_dp.sv
// datapath of the keyhold differential drive mixer: live state, settings,
// mixing stages and result registers; depends on kddm_pkg
module kddm_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  kddm_pkg::dp_cmd_t                       cmd,
	output kddm_pkg::dp_stat_t                      stat,
	input  logic                                    in_op,
	input  logic [kddm_pkg::KEY_W-1:0]              in_key,
	input  logic [kddm_pkg::DIGIT_W-1:0]            in_digit,
	input  logic                                    cfg_we,
	input  logic [kddm_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [kddm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	output logic signed [kddm_pkg::OUT_W-1:0]       left_hund,
	output logic signed [kddm_pkg::OUT_W-1:0]       right_hund,
	output logic [kddm_pkg::OUT_W-1:0]              left_pwm_code,
	output logic [kddm_pkg::OUT_W-1:0]              right_pwm_code,
	output logic                                    pwm_fmt
);

	function automatic logic is_held(kddm_pkg::age_t a, logic [kddm_pkg::TMO_BITS-1:0] tmo);
		return (a != kddm_pkg::AGE_NEVER) && (kddm_pkg::cmp_t'(a) < kddm_pkg::cmp_t'(tmo));
	endfunction

	function automatic kddm_pkg::age_t age_grow(kddm_pkg::age_t a,
			logic [kddm_pkg::TICK_W-1:0] t);
		kddm_pkg::age_ext_t sum;
		sum = kddm_pkg::age_ext_t'(a) + kddm_pkg::age_ext_t'(t);
		if (sum >= kddm_pkg::age_ext_t'(kddm_pkg::AGE_NEVER)) begin
			return kddm_pkg::AGE_NEVER;
		end
		return sum[kddm_pkg::AGE_BITS-1:0];
	endfunction

	function automatic logic [kddm_pkg::SPEED_W-1:0] clamp_speed(logic [7:0] v);
		if (v < 8'(kddm_pkg::SPEED_MIN)) begin
			return kddm_pkg::SPEED_MIN;
		end
		if (v > 8'(kddm_pkg::SPEED_MAX)) begin
			return kddm_pkg::SPEED_MAX;
		end
		return v[kddm_pkg::SPEED_W-1:0];
	endfunction

	function automatic logic [kddm_pkg::TRIM_W-1:0] clamp_trim(logic [kddm_pkg::TRIM_W-1:0] v);
		return (v < kddm_pkg::TRIM_MIN) ? kddm_pkg::TRIM_MIN : v;
	endfunction

	// input item register
	logic op_q;
	logic [kddm_pkg::KEY_W-1:0] key_q;
	logic [kddm_pkg::DIGIT_W-1:0] digit_q;

	// live state and settings
	kddm_pkg::age_t age_up_q, age_down_q, age_left_q, age_right_q;
	logic [kddm_pkg::SPEED_W-1:0] speed_q;
	logic [kddm_pkg::TRIM_W-1:0] left_trim_q, right_trim_q;
	logic pwm_mode_q;
	logic [kddm_pkg::TMO_BITS-1:0] timeout_q;
	logic [kddm_pkg::TICK_W-1:0] tick_q;

	// pipeline stages
	kddm_pkg::term_t l_term_s1, r_term_s1;
	kddm_pkg::drive_t l_n_s2, r_n_s2;
	logic [kddm_pkg::MAG_W-1:0] l_mag_s3, r_mag_s3;
	logic l_neg_s3, r_neg_s3;
	logic [kddm_pkg::X_W-1:0] l_x_s3, r_x_s3;

	// result registers
	logic signed [kddm_pkg::OUT_W-1:0] left_hund_q, right_hund_q;
	logic [kddm_pkg::OUT_W-1:0] left_pwm_q, right_pwm_q;
	logic pwm_fmt_q;

	// key-event helpers
	logic [7:0] speed_inc, digit_x10;

	// mixer decisions
	logic hu, hd, hl, hr;
	logic v_act, v_neg, h_act, h_left;
	kddm_pkg::term_t base_t, curve_t, l_term, r_term;

	// multiply and conversion
	kddm_pkg::drive_t l_prod, r_prod, l_n, r_n;
	logic signed [kddm_pkg::X_W:0] l_xs, r_xs;
	logic [29:0] l_ph, r_ph;
	logic [43:0] l_pp, r_pp;
	logic [kddm_pkg::OUT_W-1:0] l_qh, r_qh, l_qp, r_qp;

	assign stat.op_is_tick = (op_q == kddm_pkg::OP_TICK);

	assign speed_inc = 8'(speed_q) + 8'(kddm_pkg::SPEED_STEP);
	assign digit_x10 = (8'(digit_q) << 3) + (8'(digit_q) << 1);

	always_comb begin
		hu = is_held(age_up_q, timeout_q);
		hd = is_held(age_down_q, timeout_q);
		hl = is_held(age_left_q, timeout_q);
		hr = is_held(age_right_q, timeout_q);
		// older press wins a pair, a tie goes to down or right
		v_act = hu || hd;
		v_neg = hd && !(hu && (age_up_q > age_down_q));
		h_act = hl || hr;
		h_left = hl && (!hr || (age_left_q > age_right_q));
		base_t = kddm_pkg::term_t'((10'(speed_q) << 2) + 10'(speed_q));
		curve_t = kddm_pkg::term_t'((10'(speed_q) << 1) + 10'(speed_q));
		l_term = '0;
		r_term = '0;
		if (!v_act) begin
			if (h_act) begin
				l_term = h_left ? -kddm_pkg::SPIN_TERM : kddm_pkg::SPIN_TERM;
				r_term = h_left ? kddm_pkg::SPIN_TERM : -kddm_pkg::SPIN_TERM;
			end
		end else begin
			if (!h_act) begin
				l_term = base_t;
				r_term = base_t;
			end else if (h_left) begin
				l_term = curve_t;
				r_term = base_t;
			end else begin
				l_term = base_t;
				r_term = curve_t;
			end
			if (v_neg) begin
				l_term = -l_term;
				r_term = -r_term;
			end
		end
	end

	always_comb begin
		l_prod = kddm_pkg::drive_t'(l_term_s1) * kddm_pkg::drive_t'($signed({1'b0, left_trim_q}));
		r_prod = kddm_pkg::drive_t'(r_term_s1) * kddm_pkg::drive_t'($signed({1'b0, right_trim_q}));
		l_n = (l_prod > kddm_pkg::FULL_SCALE) ? kddm_pkg::FULL_SCALE :
			(l_prod < -kddm_pkg::FULL_SCALE) ? -kddm_pkg::FULL_SCALE : l_prod;
		r_n = (r_prod > kddm_pkg::FULL_SCALE) ? kddm_pkg::FULL_SCALE :
			(r_prod < -kddm_pkg::FULL_SCALE) ? -kddm_pkg::FULL_SCALE : r_prod;
		// 127*n + bias, positive for every clamped n
		l_xs = ((kddm_pkg::X_W+1)'(l_n_s2) <<< 7) - (kddm_pkg::X_W+1)'(l_n_s2)
			+ kddm_pkg::PWM_BIAS;
		r_xs = ((kddm_pkg::X_W+1)'(r_n_s2) <<< 7) - (kddm_pkg::X_W+1)'(r_n_s2)
			+ kddm_pkg::PWM_BIAS;
		// divide by 90 and by 9000 through reciprocal multiplies
		l_ph = 30'(l_mag_s3) * 30'(kddm_pkg::HUND_RECIP);
		r_ph = 30'(r_mag_s3) * 30'(kddm_pkg::HUND_RECIP);
		l_pp = 44'(l_x_s3) * 44'(kddm_pkg::PWM_RECIP);
		r_pp = 44'(r_x_s3) * 44'(kddm_pkg::PWM_RECIP);
		l_qh = l_ph[kddm_pkg::HUND_SHIFT+kddm_pkg::OUT_W-1:kddm_pkg::HUND_SHIFT];
		r_qh = r_ph[kddm_pkg::HUND_SHIFT+kddm_pkg::OUT_W-1:kddm_pkg::HUND_SHIFT];
		l_qp = l_pp[kddm_pkg::PWM_SHIFT+kddm_pkg::OUT_W-1:kddm_pkg::PWM_SHIFT];
		r_qp = r_pp[kddm_pkg::PWM_SHIFT+kddm_pkg::OUT_W-1:kddm_pkg::PWM_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_op;
			key_q <= in_key;
			digit_q <= in_digit;
		end
		if (cmd.exec) begin
			l_term_s1 <= l_term;
			r_term_s1 <= r_term;
		end
		if (cmd.mul) begin
			l_n_s2 <= l_n;
			r_n_s2 <= r_n;
		end
		if (cmd.pre) begin
			l_neg_s3 <= l_n_s2[kddm_pkg::N_W-1];
			r_neg_s3 <= r_n_s2[kddm_pkg::N_W-1];
			l_mag_s3 <= kddm_pkg::MAG_W'(l_n_s2[kddm_pkg::N_W-1] ? -l_n_s2 : l_n_s2)
				+ kddm_pkg::HUND_HALF;
			r_mag_s3 <= kddm_pkg::MAG_W'(r_n_s2[kddm_pkg::N_W-1] ? -r_n_s2 : r_n_s2)
				+ kddm_pkg::HUND_HALF;
			l_x_s3 <= kddm_pkg::X_W'(l_xs);
			r_x_s3 <= kddm_pkg::X_W'(r_xs);
		end
		if (cmd.conv) begin
			left_hund_q <= l_neg_s3 ? -l_qh : l_qh;
			right_hund_q <= r_neg_s3 ? -r_qh : r_qh;
			// quotient tops out at 254, so the code stays in range
			left_pwm_q <= l_qp + 8'd1;
			right_pwm_q <= r_qp + 8'd1;
			pwm_fmt_q <= pwm_mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_up_q <= kddm_pkg::AGE_NEVER;
			age_down_q <= kddm_pkg::AGE_NEVER;
			age_left_q <= kddm_pkg::AGE_NEVER;
			age_right_q <= kddm_pkg::AGE_NEVER;
			speed_q <= kddm_pkg::SPEED_RST;
			left_trim_q <= kddm_pkg::TRIM_RST;
			right_trim_q <= kddm_pkg::TRIM_RST;
			pwm_mode_q <= 1'b0;
			timeout_q <= kddm_pkg::TIMEOUT_RST;
			tick_q <= kddm_pkg::TICK_RST;
		end else begin
			if (cmd.exec && op_q == kddm_pkg::OP_TICK) begin
				age_up_q <= age_grow(age_up_q, tick_q);
				age_down_q <= age_grow(age_down_q, tick_q);
				age_left_q <= age_grow(age_left_q, tick_q);
				age_right_q <= age_grow(age_right_q, tick_q);
			end else if (cmd.exec) begin
				case (key_q)
					kddm_pkg::KEY_UP: begin
						age_up_q <= '0;
					end
					kddm_pkg::KEY_DOWN: begin
						age_down_q <= '0;
					end
					kddm_pkg::KEY_LEFT: begin
						age_left_q <= '0;
					end
					kddm_pkg::KEY_RIGHT: begin
						age_right_q <= '0;
					end
					kddm_pkg::KEY_STOP: begin
						age_up_q <= kddm_pkg::AGE_NEVER;
						age_down_q <= kddm_pkg::AGE_NEVER;
						age_left_q <= kddm_pkg::AGE_NEVER;
						age_right_q <= kddm_pkg::AGE_NEVER;
					end
					kddm_pkg::KEY_SPEED_UP: begin
						speed_q <= clamp_speed(speed_inc);
					end
					kddm_pkg::KEY_SPEED_DOWN: begin
						speed_q <= (speed_q < kddm_pkg::SPEED_MIN + kddm_pkg::SPEED_STEP) ?
							kddm_pkg::SPEED_MIN : speed_q - kddm_pkg::SPEED_STEP;
					end
					kddm_pkg::KEY_DIGIT: begin
						speed_q <= clamp_speed(digit_x10);
					end
					kddm_pkg::KEY_LTRIM_UP: begin
						left_trim_q <= (left_trim_q == kddm_pkg::TRIM_MAX) ?
							left_trim_q : left_trim_q + 4'd1;
					end
					kddm_pkg::KEY_LTRIM_DOWN: begin
						left_trim_q <= (left_trim_q <= kddm_pkg::TRIM_MIN) ?
							kddm_pkg::TRIM_MIN : left_trim_q - 4'd1;
					end
					kddm_pkg::KEY_RTRIM_UP: begin
						right_trim_q <= (right_trim_q == kddm_pkg::TRIM_MAX) ?
							right_trim_q : right_trim_q + 4'd1;
					end
					kddm_pkg::KEY_RTRIM_DOWN: begin
						right_trim_q <= (right_trim_q <= kddm_pkg::TRIM_MIN) ?
							kddm_pkg::TRIM_MIN : right_trim_q - 4'd1;
					end
					default: begin
					end
				endcase
			end
			if (cfg_we) begin
				case (cfg_idx)
					kddm_pkg::CFG_INITIAL_SPEED: begin
						speed_q <= clamp_speed(8'(cfg_wdata[kddm_pkg::SPEED_W-1:0]));
					end
					kddm_pkg::CFG_INITIAL_LEFT_TRIM: begin
						left_trim_q <= clamp_trim(cfg_wdata[kddm_pkg::TRIM_W-1:0]);
					end
					kddm_pkg::CFG_INITIAL_RIGHT_TRIM: begin
						right_trim_q <= clamp_trim(cfg_wdata[kddm_pkg::TRIM_W-1:0]);
					end
					kddm_pkg::CFG_PWM_MODE: begin
						pwm_mode_q <= cfg_wdata[0];
					end
					kddm_pkg::CFG_RELEASE_TIMEOUT: begin
						timeout_q <= cfg_wdata[kddm_pkg::TMO_BITS-1:0];
					end
					kddm_pkg::CFG_TICK_MS: begin
						tick_q <= cfg_wdata[kddm_pkg::TICK_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign left_hund = left_hund_q;
	assign right_hund = right_hund_q;
	assign left_pwm_code = left_pwm_q;
	assign right_pwm_code = right_pwm_q;
	assign pwm_fmt = pwm_fmt_q;

endmodule

>>> hw/rtl/keyhold_differential_drive_mixer.sv
// top level of the keyhold differential drive mixer
// depends on kddm_pkg, kddm_ctrl, kddm_dp and the assertion macro header
//
// key events and control ticks enter on one valid/ready channel. a key event
// (op 0) presses a direction, stops, or steps the speed and trims; it gives
// no result and passes through accept, then a single execute step. a tick
// (op 1) goes from accept to a result in the output register through
// execute (held test, pair resolution, mix terms, age growth), trim multiply,
// pwm pre-scale, and the reciprocal-multiply conversion to hundredths and pwm
// codes. the sequencer in kddm_ctrl takes one item at a time.
// key events are taken while a result waits on the output; a tick is taken
// only once the output register is empty or is emptied in that cycle.
// configuration writes are always ready and take effect at once; they are
// meant to be issued only while the block is idle. there is no clearing pass
// after reset.
`include "keyhold_differential_drive_mixer_assert.svh"

module keyhold_differential_drive_mixer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input item channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    op,
	input  logic [kddm_pkg::KEY_W-1:0]              key,
	input  logic [kddm_pkg::DIGIT_W-1:0]            digit,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [kddm_pkg::OUT_W-1:0]       left_hundredths,
	output logic signed [kddm_pkg::OUT_W-1:0]       right_hundredths,
	output logic [kddm_pkg::OUT_W-1:0]              left_pwm,
	output logic [kddm_pkg::OUT_W-1:0]              right_pwm,
	output logic                                    format_is_pwm,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [kddm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [kddm_pkg::CFG_DATA_W-1:0]         cfg_data
);

	kddm_pkg::dp_cmd_t cmd;
	kddm_pkg::dp_stat_t stat;
	logic cfg_we;

	// settings registers never back-pressure a write transaction
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	// sequencer: accept, execute, then the three tick stages
	kddm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (op),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// state, settings, mixer arithmetic and the result register
	kddm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_op          (op),
		.in_key         (key),
		.in_digit       (digit),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_index),
		.cfg_wdata      (cfg_data),
		.left_hund      (left_hundredths),
		.right_hund     (right_hundredths),
		.left_pwm_code  (left_pwm),
		.right_pwm_code (right_pwm),
		.pwm_fmt        (format_is_pwm)
	);

	// a result is only written into a free or draining output register
	`KDDM_ASSERT_IMP(a_conv_into_free, clk, arst_n, cmd.conv, (!out_valid || out_ready))
	// a tick transaction is only taken when its result will have room
	`KDDM_ASSERT_IMP(a_tick_needs_room, clk, arst_n, (in_valid && in_ready && op), (!out_valid || out_ready))
	// the sequencer issues at most one datapath command per cycle
	`KDDM_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd))
	// the conversion step always presents a result next cycle
	`KDDM_ASSERT_NXT(a_conv_shows_result, clk, arst_n, cmd.conv, out_valid)

endmodule

>>> tb/keyhold_differential_drive_mixer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for keyhold_differential_drive_mixer: key and tick stimulus,
// register sweeps and backpressure, with an in-bench drive command predictor
// depends on kddm_pkg and the keyhold_differential_drive_mixer rtl
module keyhold_differential_drive_mixer_tb;
	import kddm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// leave margin after a key event or tick drains, before register writes
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int ITEMS_PER_SETTING = 50;
	localparam int BACKPRESSURE_STALL = 250;

	// register settings used by the sweep
	localparam int PRESET_FLOOR = 0;
	localparam int PRESET_CEILING = 1;
	localparam int PRESET_SKEW = 2;
	localparam int PRESET_RANDOM = 3;

	// codes the block must ignore
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [KEY_W-1:0] KEY_SPARE_FIRST = 4'd12;
	localparam logic [KEY_W-1:0] KEY_SPARE_LAST = 4'd15;

	typedef struct {
		logic signed [OUT_W-1:0] left_h;
		logic signed [OUT_W-1:0] right_h;
		logic [OUT_W-1:0] left_p;
		logic [OUT_W-1:0] right_p;
		logic fmt;
	} drive_cmd_t;

	// dut pins, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic in_op = 1'b0;
	logic [KEY_W-1:0] in_key = '0;
	logic [DIGIT_W-1:0] in_digit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] left_hundredths;
	logic signed [OUT_W-1:0] right_hundredths;
	logic [OUT_W-1:0] left_pwm;
	logic [OUT_W-1:0] right_pwm;
	logic format_is_pwm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the block state and its live settings
	age_t dir_age [4];
	logic [SPEED_W-1:0] speed_lvl;
	logic [TRIM_W-1:0] ltrim_lvl;
	logic [TRIM_W-1:0] rtrim_lvl;
	logic pwm_sel;
	logic [TMO_BITS-1:0] hold_ms;
	logic [TICK_W-1:0] step_ms;

	// drive commands predicted but not yet seen on the output
	drive_cmd_t pending_cmds [$];

	int errors = 0;
	int cycle_count = 0;
	// idle odds in percent, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// long receiver hold-off, requested by the stimulus and counted by the receiver
	int hold_request = 0;
	int hold_left = 0;

	keyhold_differential_drive_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(in_op),
		.key(in_key),
		.digit(in_digit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_hundredths(left_hundredths),
		.right_hundredths(right_hundredths),
		.left_pwm(left_pwm),
		.right_pwm(right_pwm),
		.format_is_pwm(format_is_pwm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic int limit(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// drive value n/9000 to hundredths, ties rounded away from zero
	function automatic logic signed [OUT_W-1:0] to_centi(input int n);
		int mag;
		int h;
		mag = (n < 0) ? -n : n;
		h = (mag + 45) / 90;
		if (n < 0)
			h = -h;
		return OUT_W'(h);
	endfunction

	// 128 + 127*v rounded half up; the bias keeps the dividend positive
	function automatic logic [OUT_W-1:0] to_pwm_code(input int n);
		return OUT_W'(limit(1 + (127 * n + int'(PWM_BIAS)) / int'(FULL_SCALE), 0, 255));
	endfunction

	function automatic void reset_predictor();
		for (int i = 0; i < 4; i++)
			dir_age[i] = AGE_NEVER;
		speed_lvl = SPEED_RST;
		ltrim_lvl = TRIM_RST;
		rtrim_lvl = TRIM_RST;
		pwm_sel = 1'b0;
		hold_ms = TIMEOUT_RST;
		step_ms = TICK_RST;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_INITIAL_SPEED: speed_lvl = SPEED_W'(limit(int'(data[SPEED_W-1:0]),
				int'(SPEED_MIN), int'(SPEED_MAX)));
			CFG_INITIAL_LEFT_TRIM: ltrim_lvl = TRIM_W'(limit(int'(data[TRIM_W-1:0]),
				int'(TRIM_MIN), int'(TRIM_MAX)));
			CFG_INITIAL_RIGHT_TRIM: rtrim_lvl = TRIM_W'(limit(int'(data[TRIM_W-1:0]),
				int'(TRIM_MIN), int'(TRIM_MAX)));
			CFG_PWM_MODE: pwm_sel = data[0];
			CFG_RELEASE_TIMEOUT: hold_ms = data[TMO_BITS-1:0];
			CFG_TICK_MS: step_ms = data[TICK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void apply_key(input logic [KEY_W-1:0] key_code,
			input logic [DIGIT_W-1:0] dig);
		case (key_code)
			KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT: dir_age[key_code[1:0]] = '0;
			KEY_STOP: for (int i = 0; i < 4; i++) dir_age[i] = AGE_NEVER;
			KEY_SPEED_UP: speed_lvl = SPEED_W'(limit(int'(speed_lvl) + int'(SPEED_STEP),
				int'(SPEED_MIN), int'(SPEED_MAX)));
			KEY_SPEED_DOWN: speed_lvl = SPEED_W'(limit(int'(speed_lvl) - int'(SPEED_STEP),
				int'(SPEED_MIN), int'(SPEED_MAX)));
			KEY_DIGIT: speed_lvl = SPEED_W'(limit(10 * int'(dig), int'(SPEED_MIN),
				int'(SPEED_MAX)));
			KEY_LTRIM_UP: ltrim_lvl = TRIM_W'(limit(int'(ltrim_lvl) + 1, int'(TRIM_MIN),
				int'(TRIM_MAX)));
			KEY_LTRIM_DOWN: ltrim_lvl = TRIM_W'(limit(int'(ltrim_lvl) - 1, int'(TRIM_MIN),
				int'(TRIM_MAX)));
			KEY_RTRIM_UP: rtrim_lvl = TRIM_W'(limit(int'(rtrim_lvl) + 1, int'(TRIM_MIN),
				int'(TRIM_MAX)));
			KEY_RTRIM_DOWN: rtrim_lvl = TRIM_W'(limit(int'(rtrim_lvl) - 1, int'(TRIM_MIN),
				int'(TRIM_MAX)));
			default: ;
		endcase
	endfunction

	// drive command of one tick, then every age grows by the tick period
	function automatic drive_cmd_t mix_tick();
		drive_cmd_t cmd;
		bit held [4];
		int vert;
		int horiz;
		int base;
		int curve;
		int spin;
		int l;
		int r;
		age_ext_t grown;
		for (int i = 0; i < 4; i++)
			held[i] = (dir_age[i] != AGE_NEVER) && (dir_age[i] < hold_ms);
		// opposing pair: older press wins, a tie goes to down or right
		vert = 0;
		if (held[KEY_UP] && held[KEY_DOWN])
			vert = (dir_age[KEY_UP] > dir_age[KEY_DOWN]) ? 1 : -1;
		else if (held[KEY_UP])
			vert = 1;
		else if (held[KEY_DOWN])
			vert = -1;
		horiz = 0;
		if (held[KEY_LEFT] && held[KEY_RIGHT])
			horiz = (dir_age[KEY_LEFT] > dir_age[KEY_RIGHT]) ? 1 : -1;
		else if (held[KEY_LEFT])
			horiz = 1;
		else if (held[KEY_RIGHT])
			horiz = -1;
		base = 5 * int'(speed_lvl);
		curve = 3 * int'(speed_lvl);
		spin = int'(SPIN_TERM);
		l = 0;
		r = 0;
		if (vert == 0) begin
			if (horiz > 0) begin
				l = -spin;
				r = spin;
			end else if (horiz < 0) begin
				l = spin;
				r = -spin;
			end
		end else begin
			l = (horiz > 0) ? curve : base;
			r = (horiz < 0) ? curve : base;
			if (vert < 0) begin
				l = -l;
				r = -r;
			end
		end
		l = limit(l * int'(ltrim_lvl), -int'(FULL_SCALE), int'(FULL_SCALE));
		r = limit(r * int'(rtrim_lvl), -int'(FULL_SCALE), int'(FULL_SCALE));
		cmd.left_h = to_centi(l);
		cmd.right_h = to_centi(r);
		cmd.left_p = to_pwm_code(l);
		cmd.right_p = to_pwm_code(r);
		cmd.fmt = pwm_sel;
		for (int i = 0; i < 4; i++) begin
			grown = {1'b0, dir_age[i]} + step_ms;
			dir_age[i] = (grown >= AGE_NEVER) ? AGE_NEVER : grown[AGE_BITS-1:0];
		end
		return cmd;
	endfunction

	// ------------------------------------------------------------------
	// receiver side and checking
	// ------------------------------------------------------------------

	// out_ready changes on the falling edge; a hold-off request blocks it for a stretch
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// every output transaction is matched against the oldest pending command
	always @(posedge clk) begin : drive_check
		drive_cmd_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t ns: drive command with none pending, expected none actual L %0d R %0d",
					$time, left_hundredths, right_hundredths);
			end else begin
				want = pending_cmds.pop_front();
				compare_field("left_hundredths", want.left_h, left_hundredths);
				compare_field("right_hundredths", want.right_h, right_hundredths);
				compare_field("left_pwm", want.left_p, left_pwm);
				compare_field("right_pwm", want.right_p, right_pwm);
				compare_field("format_is_pwm", want.fmt, format_is_pwm);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// sender side; every task is entered and left at a falling edge
	// ------------------------------------------------------------------

	// one input transaction; in_valid stays high if the next one follows without a gap
	task automatic send_item(input op_t op_code, input logic [KEY_W-1:0] key_code,
			input logic [DIGIT_W-1:0] dig);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_op <= op_code;
		in_key <= key_code;
		in_digit <= dig;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op_code == OP_TICK)
			pending_cmds.push_back(mix_tick());
		else
			apply_key(key_code, dig);
		@(negedge clk);
	endtask

	// key and digit are don't-care on a tick, so they carry noise
	task automatic tick();
		send_item(OP_TICK, KEY_W'($urandom_range(15)), DIGIT_W'($urandom_range(15)));
	endtask

	task automatic press(input logic [KEY_W-1:0] key_code);
		send_item(OP_KEY, key_code, DIGIT_W'($urandom_range(15)));
	endtask

	// sender pauses until every pending command is out, then lets the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, data);
		@(negedge clk);
	endtask

	// full register set, with a write to an unused index slipped into the middle
	task automatic program_registers(input logic [CFG_DATA_W-1:0] speed,
			input logic [CFG_DATA_W-1:0] ltrim, input logic [CFG_DATA_W-1:0] rtrim,
			input logic [CFG_DATA_W-1:0] pwm, input logic [CFG_DATA_W-1:0] timeout_ms,
			input logic [CFG_DATA_W-1:0] tick_period);
		write_register(CFG_INITIAL_SPEED, speed);
		write_register(CFG_INITIAL_LEFT_TRIM, ltrim);
		write_register(CFG_INITIAL_RIGHT_TRIM, rtrim);
		write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_B, CFG_SPARE_A)),
			CFG_DATA_W'($urandom_range(16'hffff)));
		write_register(CFG_PWM_MODE, pwm);
		write_register(CFG_RELEASE_TIMEOUT, timeout_ms);
		write_register(CFG_TICK_MS, tick_period);
		cfg_valid <= 1'b0;
	endtask

	task automatic choose_registers(input int preset);
		logic [CFG_DATA_W-1:0] speed;
		logic [CFG_DATA_W-1:0] ltrim;
		logic [CFG_DATA_W-1:0] rtrim;
		logic [CFG_DATA_W-1:0] pwm;
		logic [CFG_DATA_W-1:0] timeout_ms;
		logic [CFG_DATA_W-1:0] tick_period;
		case (preset)
			// below range levels, zero tick: a press stays fresh forever
			PRESET_FLOOR: program_registers(0, 0, 0, 0, 1, 0);
			// all ones where the width allows
			PRESET_CEILING: program_registers(16'hffff, 16'h000f, 16'h000f, 1, 16'hffff, 16'h007f);
			PRESET_SKEW: program_registers(SPEED_MAX, TRIM_MIN, TRIM_MAX, 1, TIMEOUT_RST, 100);
			default: begin
				speed = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hffff) :
					$urandom_range(90, 9));
				ltrim = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hffff) :
					$urandom_range(15, 5));
				rtrim = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hffff) :
					$urandom_range(15, 5));
				pwm = CFG_DATA_W'($urandom_range(16'hffff));
				tick_period = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hffff) :
					$urandom_range(100, 5));
				// keep the hold window a few ticks long so releases actually happen
				if ($urandom_range(5) == 0)
					timeout_ms = CFG_DATA_W'($urandom_range(16'hffff));
				else
					timeout_ms = CFG_DATA_W'(tick_period[TICK_W-1:0] * $urandom_range(12, 1)
						+ $urandom_range(9));
				program_registers(speed, ltrim, rtrim, pwm, timeout_ms, tick_period);
			end
		endcase
	endtask

	// mostly presses followed by ticks; returns after at least count key and tick items
	task automatic send_random_traffic(input int count);
		int sent;
		int pick;
		logic [KEY_W-1:0] first;
		logic [KEY_W-1:0] second;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 28) begin
				press(KEY_W'($urandom_range(KEY_RIGHT, KEY_UP)));
				sent++;
			end else if (pick < 60) begin
				tick();
				sent++;
			end else if (pick < 70) begin
				press(KEY_W'($urandom_range(KEY_DIGIT, KEY_SPEED_UP)));
				sent++;
			end else if (pick < 80) begin
				press(KEY_W'($urandom_range(KEY_RTRIM_DOWN, KEY_LTRIM_UP)));
				sent++;
			end else if (pick < 85) begin
				press(KEY_STOP);
				sent++;
			end else if (pick < 90) begin
				// ignored codes, not counted
				press(KEY_W'($urandom_range(KEY_SPARE_LAST, KEY_SPARE_FIRST)));
			end else begin
				// opposing pair pressed back to back, then a tick sees a tie
				if ($urandom_range(1)) begin
					first = KEY_UP;
					second = KEY_DOWN;
				end else begin
					first = KEY_LEFT;
					second = KEY_RIGHT;
				end
				if ($urandom_range(1)) begin
					press(second);
					press(first);
				end else begin
					press(first);
					press(second);
				end
				tick();
				sent += 3;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset settings, every key, pair resolution, digit extremes, ignored codes
	task automatic test_directed_keys();
		tick();
		press(KEY_UP);
		tick();
		press(KEY_DOWN);
		tick();               // up is older and wins
		press(KEY_UP);
		press(KEY_DOWN);
		tick();               // equal ages, down wins
		press(KEY_STOP);
		press(KEY_LEFT);
		press(KEY_RIGHT);
		tick();               // equal ages, right wins
		press(KEY_UP);
		press(KEY_LEFT);
		tick();               // curve with the older right press
		send_item(OP_KEY, KEY_DIGIT, DIGIT_W'(0));
		send_item(OP_KEY, KEY_DIGIT, DIGIT_W'(15));
		press(KEY_SPEED_UP);  // already at the top
		tick();
		press(KEY_SPEED_DOWN);
		press(KEY_LTRIM_UP);
		press(KEY_LTRIM_DOWN);
		press(KEY_RTRIM_UP);
		press(KEY_RTRIM_DOWN);
		press(KEY_SPARE_FIRST);
		press(KEY_SPARE_LAST);
		tick();
		drain();
	endtask

	// random traffic over a series of register settings
	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
			input bit with_presets);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int b = 0; b < count / ITEMS_PER_SETTING; b++) begin
			drain();
			choose_registers((with_presets && b < PRESET_RANDOM) ? b : PRESET_RANDOM);
			send_random_traffic(ITEMS_PER_SETTING);
		end
		drain();
	endtask

	// receiver stalls long enough for the block to back up into its input
	task automatic test_output_backpressure();
		choose_registers(PRESET_RANDOM);
		hold_request = BACKPRESSURE_STALL;
		press(KEY_UP);
		press(KEY_LEFT);
		repeat (30)
			tick();
		// sender waits for the backlog to clear before going on
		drain();
		send_random_traffic(20);
		drain();
	endtask

	// a held press ages all the way into saturation and drops out
	task automatic test_age_saturation();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_registers(SPEED_MAX, TRIM_MAX, TRIM_MAX, 1, 16'hffff, 16'h007f);
		press(KEY_UP);
		repeat (300)
			tick();
		press(KEY_DOWN);
		// up saturates after about 517 ticks and down takes over
		repeat (230)
			tick();
		press(KEY_STOP);
		tick();
		drain();
	endtask

	initial begin
		reset_predictor();
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 76;
		test_directed_keys();
		test_random_traffic(150, 20, 76, 1'b1);
		test_random_traffic(150, 76, 20, 1'b0);
		test_output_backpressure();
		test_random_traffic(150, 0, 0, 1'b0);
		test_age_saturation();

		// catch any stray command after the last expected one
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
